### sv/main_bus_decode_with_palette_defines.svh
// Assertion macros shared by the bus decoder RTL.
// Included by the top level; depends on nothing else.
`ifndef MAIN_BUS_DECODE_WITH_PALETTE_DEFINES_SVH
`define MAIN_BUS_DECODE_WITH_PALETTE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbdp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MBDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbdp next-cycle check failed");

`endif

### sv/mbdp_pkg.sv
// Shared types, address map and helpers of the main bus decoder.
// Used by the register block and the top level; depends on nothing.
package mbdp_pkg;

   localparam int RAM_DEPTH     = 16384;
   localparam int RAM_ADDR_W    = $clog2(RAM_DEPTH);
   localparam int PALETTE_BYTES = 2048;
   localparam int PAL_COLORS    = PALETTE_BYTES / 2;
   localparam int PAL_ADDR_W    = $clog2(PAL_COLORS);
   // Per color: odd byte (red, green) above the blue nibble of the even byte.
   localparam int PAL_WORD_W    = 12;
   localparam int CSR_INDEX_W   = 2;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_INPUT = 2'd2,
      CMD_REPLY = 2'd3
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_B = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_C = 2'd2;

   localparam logic [15:0] RAM_BASE    = 16'hC000;
   localparam logic [15:0] SHARED_TOP  = 16'hEC02;
   localparam logic [15:0] PAL_FIRST   = 16'hD800;
   localparam logic [15:0] PAL_LAST    = 16'hDFFF;
   localparam logic [15:0] SCROLL_X_LO = 16'hEC00;
   localparam logic [15:0] SCROLL_X_HI = 16'hEC01;
   localparam logic [15:0] SCROLL_Y    = 16'hEC02;
   localparam logic [15:0] TRK_P1X     = 16'hF800;
   localparam logic [15:0] TRK_P1Y     = 16'hF801;
   localparam logic [15:0] SYS_PORT_A  = 16'hF802;
   localparam logic [15:0] P1_PORT     = 16'hF803;
   localparam logic [15:0] SYS_PORT_B  = 16'hF806;
   localparam logic [15:0] TRK_P2X     = 16'hF810;
   localparam logic [15:0] TRK_P2Y     = 16'hF811;
   localparam logic [15:0] P2_PORT     = 16'hF813;
   localparam logic [15:0] SOUND_PORT  = 16'hF820;
   localparam logic [15:0] SUB_DIP_A   = 16'hF840;
   localparam logic [15:0] DIP_B_PORT  = 16'hF850;
   localparam logic [15:0] DIP_C_PORT  = 16'hF870;

   localparam logic [7:0] FIRE_PORT_RST = 8'h20;
   localparam logic [7:0] SYS_PORT_RST  = 8'h0F;
   localparam logic [7:0] OPEN_BUS      = 8'hFF;
   localparam logic [7:0] STICK_STEP    = 8'd8;

   typedef struct packed {
      logic       commit;
      cmd_type    cmd;
      logic [15:0] address;
      logic [7:0] wdata;
      logic [5:0] buttons;
      logic [7:0] dirs;
   } io_update_type;

   // Register values as they stand after the committed transaction.
   typedef struct packed {
      logic [8:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] sound_cmd;
      logic       sub_held;
      logic       strobe;
      logic       pulse;
   } io_status_type;

   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

endpackage

### sv/mbdp_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Depends on nothing; used for the shared RAM and the palette store.
module mbdp_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mbdp_io_regs.sv
// I/O register file: DIP banks, scroll, trackball, stick, buttons, latches.
// Depends on mbdp_pkg for the address map and the update/status structs.
module mbdp_io_regs import mbdp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_write_data,
   input  io_update_type          upd,
   output logic [7:0]             port_data,
   output io_status_type          status
);

   logic [7:0] dip_a_ff, dip_b_ff, dip_c_ff;
   logic [8:0] scroll_x_ff, scroll_x_in;
   logic [7:0] scroll_y_ff, scroll_y_in;
   logic [7:0] track_ff [4];
   logic [7:0] track_in [4];
   logic [7:0] stick_ff [4];
   logic [7:0] stick_in [4];
   logic [7:0] btn_ff [3];
   logic [7:0] btn_in [3];
   logic [7:0] cmd_latch_ff, cmd_latch_in;
   logic [7:0] reply_ff, reply_in;
   logic       sub_held_ff, sub_held_in;
   logic       strobe, pulse;

   function automatic logic [7:0] axis_delta(input logic plus, input logic minus);
      logic [7:0] d;
      d = 8'd0;
      if (plus && !minus) begin
         d = STICK_STEP;
      end else if (minus && !plus) begin
         d = 8'd0 - STICK_STEP;
      end
      return d;
   endfunction

   always_comb begin
      scroll_x_in  = scroll_x_ff;
      scroll_y_in  = scroll_y_ff;
      track_in     = track_ff;
      stick_in     = stick_ff;
      btn_in       = btn_ff;
      cmd_latch_in = cmd_latch_ff;
      reply_in     = reply_ff;
      sub_held_in  = sub_held_ff;
      strobe       = 1'b0;
      pulse        = 1'b0;
      if (upd.commit) begin
         unique case (upd.cmd)
            CMD_WRITE: begin
               unique case (upd.address)
                  SCROLL_X_LO: scroll_x_in = {scroll_x_ff[8], upd.wdata};
                  SCROLL_X_HI: scroll_x_in = {upd.wdata[0], scroll_x_ff[7:0]};
                  SCROLL_Y:    scroll_y_in = upd.wdata;
                  TRK_P1X:     track_in[0] = upd.wdata;
                  TRK_P1Y:     track_in[1] = upd.wdata;
                  TRK_P2X:     track_in[2] = upd.wdata;
                  TRK_P2Y:     track_in[3] = upd.wdata;
                  SOUND_PORT: begin
                     cmd_latch_in = upd.wdata;
                     strobe       = 1'b1;
                  end
                  SUB_DIP_A: begin
                     sub_held_in = (upd.wdata == 8'd0);
                     pulse       = (upd.wdata == 8'd0);
                  end
                  default: ;
               endcase
            end
            CMD_INPUT: begin
               // A pressed button pulls its bit low.
               btn_in[0] = FIRE_PORT_RST & {2'b11, ~upd.buttons[0], 5'b11111};
               btn_in[1] = FIRE_PORT_RST & {2'b11, ~upd.buttons[1], 5'b11111};
               btn_in[2] = SYS_PORT_RST & {4'hF, ~upd.buttons[5:2]};
               stick_in[0] = axis_delta(upd.dirs[0], upd.dirs[1]);
               stick_in[1] = axis_delta(upd.dirs[2], upd.dirs[3]);
               stick_in[2] = axis_delta(upd.dirs[4], upd.dirs[5]);
               stick_in[3] = axis_delta(upd.dirs[6], upd.dirs[7]);
            end
            CMD_REPLY: reply_in = upd.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (upd.address)
         TRK_P1X:    port_data = track_ff[0] - stick_ff[0];
         TRK_P1Y:    port_data = track_ff[1] - stick_ff[1];
         TRK_P2X:    port_data = track_ff[2] - stick_ff[2];
         TRK_P2Y:    port_data = track_ff[3] - stick_ff[3];
         SYS_PORT_A: port_data = btn_ff[2];
         SYS_PORT_B: port_data = btn_ff[2];
         P1_PORT:    port_data = btn_ff[0];
         P2_PORT:    port_data = btn_ff[1];
         SOUND_PORT: port_data = reply_ff;
         SUB_DIP_A:  port_data = dip_a_ff;
         DIP_B_PORT: port_data = dip_b_ff;
         DIP_C_PORT: port_data = dip_c_ff;
         default:    port_data = OPEN_BUS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff     <= 8'd0;
         dip_b_ff     <= 8'd0;
         dip_c_ff     <= 8'd0;
         scroll_x_ff  <= 9'd0;
         scroll_y_ff  <= 8'd0;
         track_ff     <= '{default: 8'd0};
         stick_ff     <= '{default: 8'd0};
         btn_ff[0]    <= FIRE_PORT_RST;
         btn_ff[1]    <= FIRE_PORT_RST;
         btn_ff[2]    <= SYS_PORT_RST;
         cmd_latch_ff <= 8'd0;
         reply_ff     <= 8'd0;
         sub_held_ff  <= 1'b1;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DIP_A: dip_a_ff <= csr_write_data;
               CSR_DIP_B: dip_b_ff <= csr_write_data;
               CSR_DIP_C: dip_c_ff <= csr_write_data;
               default: ;
            endcase
         end
         scroll_x_ff  <= scroll_x_in;
         scroll_y_ff  <= scroll_y_in;
         track_ff     <= track_in;
         stick_ff     <= stick_in;
         btn_ff       <= btn_in;
         cmd_latch_ff <= cmd_latch_in;
         reply_ff     <= reply_in;
         sub_held_ff  <= sub_held_in;
      end
   end

   assign status = '{scroll_x:  scroll_x_in,
                     scroll_y:  scroll_y_in,
                     sound_cmd: cmd_latch_in,
                     sub_held:  sub_held_in,
                     strobe:    strobe,
                     pulse:     pulse};

endmodule

### sv/main_bus_decode_with_palette.sv
// Top level of the main-processor bus decoder with palette expansion.
// Depends on mbdp_pkg, mbdp_ram, mbdp_io_regs and the assertion macro header.

// At the accept edge a transaction issues the reads of the shared RAM and of
// the palette store; the commit edge, which waits while an earlier result is
// not yet taken, then commits the register and memory writes and loads the
// result register. A new transaction can be taken the cycle after commit, so
// the block takes no new transaction until the one it holds has committed;
// a waiting result holds only the transaction behind it. After reset the
// palette store is cleared one color per cycle, all 1024 colors, and no
// transaction is accepted during that pass; DIP switch writes are taken at
// any time. The shared RAM is not cleared, and reading a byte that was never
// written returns an undefined value.
`include "main_bus_decode_with_palette_defines.svh"

module main_bus_decode_with_palette import mbdp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_write_data,
   input  logic [5:0]             req_button_bits,
   input  logic [7:0]             req_direction_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_rom_read,
   output logic                   rsp_palette_update,
   output logic [9:0]             rsp_palette_index,
   output logic [23:0]            rsp_palette_rgb,
   output logic [8:0]             rsp_scroll_horizontal,
   output logic [7:0]             rsp_scroll_vertical,
   output logic                   rsp_sound_command_strobe,
   output logic [7:0]             rsp_sound_command,
   output logic                   rsp_sub_cpu_held,
   output logic                   rsp_sub_cpu_reset_pulse
);

   logic                  clear_ff, clear_in;
   logic [PAL_ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   cmd_type     s1_cmd_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_wdata_ff;
   logic [5:0]  s1_btn_ff;
   logic [7:0]  s1_dir_ff;

   logic [7:0]  rd_data_ff;
   logic        rom_ff, pal_upd_ff, strobe_ff, pulse_ff, sub_held_ff;
   logic [9:0]  pal_index_ff;
   logic [23:0] pal_rgb_ff;
   logic [8:0]  scroll_x_ff;
   logic [7:0]  scroll_y_ff;
   logic [7:0]  sound_cmd_ff;

   logic req_accept, commit;
   logic s1_is_write, s1_in_ram, s1_pal_hit;

   logic [15:0]           req_ram_offset, s1_ram_offset;
   logic                  ram_rd_en, ram_wr_en;
   logic [7:0]            ram_rd_data;
   logic                  pal_wr_en;
   logic [PAL_ADDR_W-1:0] pal_wr_addr;
   logic [PAL_WORD_W-1:0] pal_wr_data, pal_rd_data, pal_word_new;

   logic [7:0]    port_data, read_byte;
   logic          rom_hit;
   io_update_type upd;
   io_status_type status;

   assign req_ready  = !s1_valid_ff && !clear_ff;
   assign req_accept = req_valid && req_ready;
   assign commit     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign s1_is_write = (s1_cmd_ff == CMD_WRITE);
   assign s1_in_ram   = (s1_addr_ff >= RAM_BASE) && (s1_addr_ff <= SHARED_TOP);
   assign s1_pal_hit  = s1_is_write && (s1_addr_ff >= PAL_FIRST) &&
                        (s1_addr_ff <= PAL_LAST);

   // Shared RAM: read at accept, written at commit, so the two never overlap.
   assign req_ram_offset = req_address - RAM_BASE;
   assign s1_ram_offset  = s1_addr_ff - RAM_BASE;
   assign ram_rd_en      = req_accept && (cmd_type'(req_cmd) == CMD_READ);
   assign ram_wr_en      = commit && s1_is_write && s1_in_ram;

   mbdp_ram #(
      .ADDR_W (RAM_ADDR_W),
      .DATA_W (8)
   ) u_shared_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ram_offset[RAM_ADDR_W-1:0]),
      .wr_data (s1_wdata_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (req_ram_offset[RAM_ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Palette store holds one color per word; a byte write merges into it.
   assign pal_word_new = s1_addr_ff[0] ? {s1_wdata_ff, pal_rd_data[3:0]}
                                       : {pal_rd_data[11:4], s1_wdata_ff[3:0]};
   assign pal_wr_en    = clear_ff || (commit && s1_pal_hit);
   assign pal_wr_addr  = clear_ff ? clear_cnt_ff : s1_addr_ff[PAL_ADDR_W:1];
   assign pal_wr_data  = clear_ff ? '0 : pal_word_new;

   mbdp_ram #(
      .ADDR_W (PAL_ADDR_W),
      .DATA_W (PAL_WORD_W)
   ) u_palette_mem (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_address[PAL_ADDR_W:1]),
      .rd_data (pal_rd_data)
   );

   assign upd = '{commit:  commit,
                  cmd:     s1_cmd_ff,
                  address: s1_addr_ff,
                  wdata:   s1_wdata_ff,
                  buttons: s1_btn_ff,
                  dirs:    s1_dir_ff};

   mbdp_io_regs u_io_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .upd            (upd),
      .port_data      (port_data),
      .status         (status)
   );

   always_comb begin
      read_byte = 8'd0;
      rom_hit   = 1'b0;
      if (s1_cmd_ff == CMD_READ) begin
         if (s1_addr_ff < RAM_BASE) begin
            rom_hit = 1'b1;
         end else if (s1_addr_ff <= SHARED_TOP) begin
            read_byte = ram_rd_data;
         end else begin
            read_byte = port_data;
         end
      end
   end

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + PAL_ADDR_W'(1);
         clear_in     = (clear_cnt_ff != '1);
      end
      s1_valid_in  = req_accept || (s1_valid_ff && !commit);
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= cmd_type'(req_cmd);
         s1_addr_ff  <= req_address;
         s1_wdata_ff <= req_write_data;
         s1_btn_ff   <= req_button_bits;
         s1_dir_ff   <= req_direction_bits;
      end
      if (commit) begin
         rd_data_ff   <= read_byte;
         rom_ff       <= rom_hit;
         pal_upd_ff   <= s1_pal_hit;
         pal_index_ff <= s1_pal_hit ? s1_addr_ff[PAL_ADDR_W:1] : 10'd0;
         pal_rgb_ff   <= s1_pal_hit ? {widen4(pal_word_new[7:4]),
                                       widen4(pal_word_new[11:8]),
                                       widen4(pal_word_new[3:0])} : 24'd0;
         scroll_x_ff  <= status.scroll_x;
         scroll_y_ff  <= status.scroll_y;
         strobe_ff    <= status.strobe;
         sound_cmd_ff <= status.sound_cmd;
         sub_held_ff  <= status.sub_held;
         pulse_ff     <= status.pulse;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_read_data            = rd_data_ff;
   assign rsp_rom_read             = rom_ff;
   assign rsp_palette_update       = pal_upd_ff;
   assign rsp_palette_index        = pal_index_ff;
   assign rsp_palette_rgb          = pal_rgb_ff;
   assign rsp_scroll_horizontal    = scroll_x_ff;
   assign rsp_scroll_vertical      = scroll_y_ff;
   assign rsp_sound_command_strobe = strobe_ff;
   assign rsp_sound_command        = sound_cmd_ff;
   assign rsp_sub_cpu_held         = sub_held_ff;
   assign rsp_sub_cpu_reset_pulse  = pulse_ff;

   // Only one transaction is ever between accept and commit.
   `MBDP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_accept, s1_valid_ff && !req_ready)
   // The clearing pass owns the palette port and keeps the pipeline empty.
   `MBDP_ASSERT_IMPL(a_clear_quiet, clock, reset, clear_ff, !s1_valid_ff && !ram_wr_en)
   // A committed transaction always shows up as a result.
   `MBDP_ASSERT_NEXT(a_commit_result, clock, reset, commit, rsp_valid)
   // A palette write carries no read byte, ROM flag or sound strobe.
   `MBDP_ASSERT_IMPL(a_palette_alone, clock, reset, rsp_valid && rsp_palette_update,
      rsp_read_data == 8'd0 && !rsp_rom_read && !rsp_sound_command_strobe)

endmodule

### verif/main_bus_decode_with_palette_tb.sv
// Self-checking testbench for the main bus decoder with palette expansion.
// Depends on mbdp_pkg and the main_bus_decode_with_palette RTL; nothing else.
module main_bus_decode_with_palette_tb import mbdp_pkg::*; ();

   localparam int STALL_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [5:0]  buttons;
      logic [7:0]  dirs;
   } bus_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        rom_read;
      logic        palette_update;
      logic [9:0]  palette_index;
      logic [23:0] palette_rgb;
      logic [8:0]  scroll_h;
      logic [7:0]  scroll_v;
      logic        strobe;
      logic [7:0]  sound_cmd;
      logic        held;
      logic        pulse;
   } bus_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DIP_A;
   logic [7:0]             csr_write_data = 8'h00;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_cmd = CMD_READ;
   logic [15:0]            req_address = 16'h0000;
   logic [7:0]             req_write_data = 8'h00;
   logic [5:0]             req_button_bits = 6'h00;
   logic [7:0]             req_direction_bits = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_read_data;
   logic                   rsp_rom_read;
   logic                   rsp_palette_update;
   logic [9:0]             rsp_palette_index;
   logic [23:0]            rsp_palette_rgb;
   logic [8:0]             rsp_scroll_horizontal;
   logic [7:0]             rsp_scroll_vertical;
   logic                   rsp_sound_command_strobe;
   logic [7:0]             rsp_sound_command;
   logic                   rsp_sub_cpu_held;
   logic                   rsp_sub_cpu_reset_pulse;

   // Stimulus side: pending transactions and the RAM bytes they will have written.
   bus_req_type pending_q[$];
   logic [15:0] ram_written_q[$];
   bit          ram_written [0:RAM_DEPTH-1];
   bus_req_type cur_req;
   bit          req_busy = 1'b0;
   bit          calm = 1'b0;
   logic [15:0] read_ports [0:11] = '{TRK_P1X, TRK_P1Y, SYS_PORT_A, P1_PORT, SYS_PORT_B,
                                      TRK_P2X, TRK_P2Y, P2_PORT, SOUND_PORT, SUB_DIP_A,
                                      DIP_B_PORT, DIP_C_PORT};
   logic [15:0] write_ports [0:5] = '{TRK_P1X, TRK_P1Y, TRK_P2X, TRK_P2Y, SOUND_PORT,
                                      SUB_DIP_A};

   // Predicted decoder state.
   logic [7:0] ram_img [0:RAM_DEPTH-1];
   logic [7:0] pal_img [0:PALETTE_BYTES-1] = '{default: 8'h00};
   logic [8:0] scroll_x = 9'h000;
   logic [7:0] scroll_y = 8'h00;
   logic [7:0] trk_reg [0:3] = '{default: 8'h00};
   logic [7:0] stick_delta [0:3] = '{default: 8'h00};
   logic [7:0] btn_port [0:2] = '{FIRE_PORT_RST, FIRE_PORT_RST, SYS_PORT_RST};
   logic [7:0] sound_latch = 8'h00;
   logic [7:0] reply_latch = 8'h00;
   logic       sub_held = 1'b1;
   logic [7:0] dip_cfg [0:2] = '{default: 8'h00};

   bus_rsp_type expected_q[$];
   int          stall_cycles = 0;
   int          mismatches = 0;
   int          checked = 0;
   int          palette_hits = 0;
   int          cmd_count [0:3] = '{default: 0};

   main_bus_decode_with_palette DUT (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_address(req_address), .req_write_data(req_write_data),
      .req_button_bits(req_button_bits), .req_direction_bits(req_direction_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data),
      .rsp_rom_read(rsp_rom_read), .rsp_palette_update(rsp_palette_update),
      .rsp_palette_index(rsp_palette_index), .rsp_palette_rgb(rsp_palette_rgb),
      .rsp_scroll_horizontal(rsp_scroll_horizontal),
      .rsp_scroll_vertical(rsp_scroll_vertical),
      .rsp_sound_command_strobe(rsp_sound_command_strobe),
      .rsp_sound_command(rsp_sound_command), .rsp_sub_cpu_held(rsp_sub_cpu_held),
      .rsp_sub_cpu_reset_pulse(rsp_sub_cpu_reset_pulse)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] axis_step(logic plus, logic minus);
      logic [7:0] d;
      d = 8'h00;
      if (plus) d = d + STICK_STEP;
      if (minus) d = d - STICK_STEP;
      return d;
   endfunction

   // Applies one transaction to the predicted state and returns its result.
   function automatic bus_rsp_type compute_bus_result(bus_req_type r);
      bus_rsp_type res;
      logic [7:0]  lo, hi;
      res = '0;
      case (r.cmd)
         CMD_READ: begin
            if (r.addr < RAM_BASE) res.rom_read = 1'b1;
            else if (r.addr <= SHARED_TOP) res.read_data = ram_img[r.addr - RAM_BASE];
            else begin
               case (r.addr)
                  TRK_P1X:                res.read_data = trk_reg[0] - stick_delta[0];
                  TRK_P1Y:                res.read_data = trk_reg[1] - stick_delta[1];
                  TRK_P2X:                res.read_data = trk_reg[2] - stick_delta[2];
                  TRK_P2Y:                res.read_data = trk_reg[3] - stick_delta[3];
                  SYS_PORT_A, SYS_PORT_B: res.read_data = btn_port[2];
                  P1_PORT:                res.read_data = btn_port[0];
                  P2_PORT:                res.read_data = btn_port[1];
                  SOUND_PORT:             res.read_data = reply_latch;
                  SUB_DIP_A:              res.read_data = dip_cfg[CSR_DIP_A];
                  DIP_B_PORT:             res.read_data = dip_cfg[CSR_DIP_B];
                  DIP_C_PORT:             res.read_data = dip_cfg[CSR_DIP_C];
                  default:                res.read_data = OPEN_BUS;
               endcase
            end
         end
         CMD_WRITE: begin
            if (r.addr >= RAM_BASE && r.addr <= SHARED_TOP) begin
               ram_img[r.addr - RAM_BASE] = r.wdata;
               if (r.addr >= PAL_FIRST && r.addr <= PAL_LAST) begin
                  // Blue sits in the even byte, red and green in the odd byte.
                  pal_img[r.addr[10:0]] = r.wdata;
                  lo = pal_img[{r.addr[10:1], 1'b0}];
                  hi = pal_img[{r.addr[10:1], 1'b1}];
                  res.palette_update = 1'b1;
                  res.palette_index = r.addr[10:1];
                  res.palette_rgb = {hi[3:0], hi[3:0], hi[7:4], hi[7:4], lo[3:0], lo[3:0]};
               end else if (r.addr == SCROLL_X_LO) scroll_x[7:0] = r.wdata;
               else if (r.addr == SCROLL_X_HI) scroll_x[8] = r.wdata[0];
               else if (r.addr == SCROLL_Y) scroll_y = r.wdata;
            end else begin
               case (r.addr)
                  TRK_P1X:    trk_reg[0] = r.wdata;
                  TRK_P1Y:    trk_reg[1] = r.wdata;
                  TRK_P2X:    trk_reg[2] = r.wdata;
                  TRK_P2Y:    trk_reg[3] = r.wdata;
                  SOUND_PORT: begin
                     sound_latch = r.wdata;
                     res.strobe = 1'b1;
                  end
                  SUB_DIP_A: begin
                     sub_held = (r.wdata == 8'h00);
                     res.pulse = sub_held;
                  end
                  default: ;
               endcase
            end
         end
         CMD_INPUT: begin
            // A pressed button pulls its port bit low.
            btn_port[0] = {2'b00, ~r.buttons[0], 5'b00000};
            btn_port[1] = {2'b00, ~r.buttons[1], 5'b00000};
            btn_port[2] = {4'h0, ~r.buttons[5:2]};
            stick_delta[0] = axis_step(r.dirs[0], r.dirs[1]);
            stick_delta[1] = axis_step(r.dirs[2], r.dirs[3]);
            stick_delta[2] = axis_step(r.dirs[4], r.dirs[5]);
            stick_delta[3] = axis_step(r.dirs[6], r.dirs[7]);
         end
         default: reply_latch = r.wdata;
      endcase
      res.scroll_h = scroll_x;
      res.scroll_v = scroll_y;
      res.sound_cmd = sound_latch;
      res.held = sub_held;
      return res;
   endfunction

   function automatic string show(bus_rsp_type r);
      return {$sformatf("rd=%02h rom=%0b pal=%0b idx=%0d rgb=%06h ",
                        r.read_data, r.rom_read, r.palette_update, r.palette_index,
                        r.palette_rgb),
              $sformatf("sx=%03h sy=%02h stb=%0b snd=%02h held=%0b rst=%0b",
                        r.scroll_h, r.scroll_v, r.strobe, r.sound_cmd, r.held, r.pulse)};
   endfunction

   function automatic void add_item(cmd_type c, logic [15:0] a, logic [7:0] d,
                                    logic [5:0] b, logic [7:0] s);
      bus_req_type r;
      r = '{cmd: c, addr: a, wdata: d, buttons: b, dirs: s};
      if (c == CMD_WRITE && a >= RAM_BASE && a <= SHARED_TOP &&
          !ram_written[a - RAM_BASE]) begin
         ram_written[a - RAM_BASE] = 1'b1;
         ram_written_q = {ram_written_q, a};
      end
      pending_q = {pending_q, r};
   endfunction

   task automatic add_random_items(int count);
      bus_req_type r;
      int          pick;
      repeat (count) begin
         r.cmd = CMD_READ;
         r.addr = 16'($urandom);
         r.wdata = 8'($urandom);
         r.buttons = 6'($urandom);
         r.dirs = 8'($urandom);
         pick = $urandom_range(99);
         if (pick < 30) begin
            pick = $urandom_range(99);
            if (pick < 40 && ram_written_q.size() > 0)
               r.addr = ram_written_q[$urandom_range(ram_written_q.size() - 1)];
            else if (pick < 70) r.addr = read_ports[$urandom_range(11)];
            else if (pick < 80) r.addr = 16'($urandom_range(RAM_BASE - 1));
            else if (pick < 90) r.addr = 16'($urandom_range(16'hFFFF, SHARED_TOP + 1));
            // RAM that holds no data yet is never read; fold such a read into ROM.
            if (r.addr >= RAM_BASE && r.addr <= SHARED_TOP &&
                !ram_written[r.addr - RAM_BASE])
               r.addr = r.addr - RAM_BASE;
         end else if (pick < 65) begin
            r.cmd = CMD_WRITE;
            pick = $urandom_range(99);
            if (pick < 35) r.addr = 16'(PAL_FIRST + $urandom_range(PALETTE_BYTES - 1));
            else if (pick < 45) r.addr = 16'(SCROLL_X_LO + $urandom_range(2));
            else if (pick < 65) begin
               r.addr = write_ports[$urandom_range(5)];
               if (r.addr == SUB_DIP_A && $urandom_range(1) == 0) r.wdata = 8'h00;
            end else if (pick < 85)
               r.addr = 16'(RAM_BASE + $urandom_range(SHARED_TOP - RAM_BASE));
         end else if (pick < 85) r.cmd = CMD_INPUT;
         else r.cmd = CMD_REPLY;
         add_item(r.cmd, r.addr, r.wdata, r.buttons, r.dirs);
      end
   endtask

   task automatic write_dip(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      dip_cfg[idx] = value;
   endtask

   task automatic wait_for_results();
      while (pending_q.size() != 0 || req_busy || expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: a transaction stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_busy) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
               cur_req = pending_q.pop_front();
               req_busy = 1'b1;
               req_valid <= 1'b1;
               req_cmd <= cur_req.cmd;
               req_address <= cur_req.addr;
               req_write_data <= cur_req.wdata;
               req_button_bits <= cur_req.buttons;
               req_direction_bits <= cur_req.dirs;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   // Monitor: results are checked before the same-edge request is predicted.
   always @(posedge clock) begin : monitor
      bus_rsp_type got, want;
      bit          progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            got = {rsp_read_data, rsp_rom_read, rsp_palette_update, rsp_palette_index,
                   rsp_palette_rgb, rsp_scroll_horizontal, rsp_scroll_vertical,
                   rsp_sound_command_strobe, rsp_sound_command, rsp_sub_cpu_held,
                   rsp_sub_cpu_reset_pulse};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: result with no transaction pending: %s", show(got));
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("ERROR: result %0d differs", checked);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            progress = 1'b1;
            want = compute_bus_result(cur_req);
            expected_q = {expected_q, want};
            cmd_count[cur_req.cmd]++;
            if (want.palette_update) palette_hits++;
            req_busy = 1'b0;
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
      end
   end

   // The limit covers the palette clearing pass after reset with a wide margin.
   initial begin
      @(negedge reset);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_dip(CSR_DIP_A, 8'h00);
      write_dip(CSR_DIP_B, 8'hFF);
      write_dip(CSR_DIP_C, 8'h3C);

      add_item(CMD_READ, 16'h0000, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, RAM_BASE - 16'd1, 8'h55, 6'h00, 8'h00);
      add_item(CMD_READ, SYS_PORT_A, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, RAM_BASE, 8'hA5, 6'h00, 8'h00);
      add_item(CMD_READ, RAM_BASE, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, PAL_FIRST, 8'h0F, 6'h00, 8'h00);
      add_item(CMD_WRITE, PAL_FIRST + 16'd1, 8'hFF, 6'h00, 8'h00);
      add_item(CMD_WRITE, PAL_LAST, 8'h5A, 6'h00, 8'h00);
      add_item(CMD_WRITE, PAL_LAST - 16'd1, 8'hC3, 6'h00, 8'h00);
      add_item(CMD_WRITE, SCROLL_X_LO, 8'hFF, 6'h00, 8'h00);
      add_item(CMD_WRITE, SCROLL_X_HI, 8'h01, 6'h00, 8'h00);
      add_item(CMD_WRITE, SCROLL_Y, 8'h80, 6'h00, 8'h00);
      add_item(CMD_READ, SCROLL_Y, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, TRK_P1X, 8'h10, 6'h00, 8'h00);
      // Every button pressed, and opposite stick directions cancel.
      add_item(CMD_INPUT, 16'h0000, 8'h00, 6'h3F, 8'hFF);
      add_item(CMD_READ, SYS_PORT_B, 8'h00, 6'h00, 8'h00);
      add_item(CMD_INPUT, 16'h0000, 8'h00, 6'h00, 8'h01);
      add_item(CMD_READ, TRK_P1X, 8'h00, 6'h00, 8'h00);
      add_item(CMD_INPUT, 16'h0000, 8'h00, 6'h15, 8'h82);
      add_item(CMD_READ, TRK_P2Y, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, SOUND_PORT, 8'h77, 6'h00, 8'h00);
      add_item(CMD_REPLY, 16'h0000, 8'h99, 6'h00, 8'h00);
      add_item(CMD_READ, SOUND_PORT, 8'h00, 6'h00, 8'h00);
      add_item(CMD_WRITE, SUB_DIP_A, 8'h00, 6'h00, 8'h00);
      add_item(CMD_READ, 16'hFFFF, 8'h00, 6'h00, 8'h00);
      add_random_items(600);
      wait_for_results();

      write_dip(CSR_DIP_A, 8'hFF);
      write_dip(CSR_DIP_B, 8'h00);
      write_dip(CSR_DIP_C, 8'hA5);
      calm = 1'b1;
      add_random_items(575);
      wait_for_results();

      calm = 1'b0;
      write_dip(CSR_DIP_A, 8'($urandom));
      write_dip(CSR_DIP_B, 8'($urandom));
      write_dip(CSR_DIP_C, 8'($urandom));
      add_random_items(550);
      wait_for_results();
      repeat (8) @(negedge clock);

      $display("Run covered %0d reads, %0d writes with %0d palette updates,",
               cmd_count[CMD_READ], cmd_count[CMD_WRITE], palette_hits);
      $display("%0d input updates and %0d reply latch writes over three DIP settings; %0d checked.",
               cmd_count[CMD_INPUT], cmd_count[CMD_REPLY], checked);
      if (expected_q.size() != 0)
         $display("ERROR: %0d results never arrived", expected_q.size());
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
